### rtl/lpwp_pkg.sv
// types, constants and slot encoding shared by the led pulse word packer
`timescale 1ns / 1ps
`default_nettype none

package lpwp_pkg;

  localparam int WORD_BITS = 32;
  localparam int LED_SLOTS = 72;
  localparam int MAX_WORDS = 5;
  localparam int FILL_W    = $clog2(WORD_BITS);
  localparam int SPAN      = WORD_BITS + LED_SLOTS + WORD_BITS;
  localparam int PTR_W     = $clog2(MAX_WORDS + 1);

  localparam logic [15:0] LIMIT_RESET = 16'd1016;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [LED_SLOTS-1:0] slots_t;

  typedef struct packed {
    word_t data;
    logic  last_word;
    logic  limit_hit;
  } entry_t;

  // green, red, blue, msb first; each bit becomes 1, bit, 0
  function automatic slots_t led_slots(input logic [7:0] g, input logic [7:0] r,
                                       input logic [7:0] b);
    logic [23:0] bits;
    slots_t      s;
    bits = {g, r, b};
    s = '0;
    for (int i = 0; i < 24; i++) begin
      s[3*i +: 3] = {1'b1, bits[i], 1'b0};
    end
    return s;
  endfunction

endpackage

`default_nettype wire

### rtl/led_pulse_word_packer.sv
// led pulse word packer: led colours in, packed 32-slot words out
//
//   channel  handshake               payload
//   in       in_valid / in_stall     red, green, blue, last_led
//   out      out_valid / out_stall   word, last_word, limit_hit
//   cfg      cfg_wr_en               cfg_wr_data (word limit)
//
// an item is packed from the input register into a five-entry result
// buffer, which sends one word per cycle while out_stall is low: 2 or 3
// words per item, 4 or 5 on the last led, fewer on the item whose word
// reaches the limit, none for an item dropped after the limit.
// the next item is taken while the buffer drains its last word.
// rst is synchronous and clears the frame state and sets the limit to 1016.
// a stall on out holds the current word and backs up into in_stall.
`timescale 1ns / 1ps
`default_nettype none

module led_pulse_word_packer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  red,
  input  wire logic [7:0]  green,
  input  wire logic [7:0]  blue,
  input  wire logic        last_led,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      word,
  output logic             last_word,
  output logic             limit_hit
);

  localparam int WB = lpwp_pkg::WORD_BITS;
  localparam int SP = lpwp_pkg::SPAN;
  localparam int PW = lpwp_pkg::PTR_W;
  localparam int FW = lpwp_pkg::FILL_W;
  localparam int NW = lpwp_pkg::MAX_WORDS;

  // configuration and frame state
  logic [15:0]     limit;
  lpwp_pkg::word_t pending;
  logic [FW-1:0]   fill;
  logic [15:0]     words_sent;
  logic            stopped;

  // input register
  logic       ir_valid;
  logic [7:0] ir_red;
  logic [7:0] ir_green;
  logic [7:0] ir_blue;
  logic       ir_last;

  // result buffer
  lpwp_pkg::entry_t entries [NW];
  logic [PW-1:0]    rd_ptr;
  logic [PW-1:0]    left;

  logic out_take;
  logic drain_done;
  logic advance;
  logic in_take;

  // packing logic
  logic [FW+2:0]    total;
  logic             three;
  logic [SP-1:0]    stream;
  lpwp_pkg::word_t  cand [NW];
  logic [NW-1:0]    hit;
  logic [NW-1:0]    fin;
  logic [PW-1:0]    k;
  logic [PW-1:0]    m;
  logic [NW-1:0]    kmask;
  lpwp_pkg::word_t  pending_next;
  logic [FW-1:0]    fill_next;
  logic [FW+2:0]    rem;

  assign out_valid  = (left != '0);
  assign out_take   = out_valid && !out_stall;
  assign drain_done = (left == '0) || ((left == PW'(1)) && out_take);
  assign advance    = ir_valid && drain_done;
  assign in_stall   = ir_valid && !drain_done;
  assign in_take    = in_valid && !in_stall;

  assign word      = entries[rd_ptr].data;
  assign last_word = entries[rd_ptr].last_word;
  assign limit_hit = entries[rd_ptr].limit_hit;

  always_comb begin
    total  = {3'b000, fill} + (FW+3)'(lpwp_pkg::LED_SLOTS);
    three  = total >= (FW+3)'(3 * WB);
    stream = {pending, {(SP-WB){1'b0}}}
           | ({lpwp_pkg::led_slots(ir_green, ir_red, ir_blue),
               {(SP-lpwp_pkg::LED_SLOTS){1'b0}}} >> fill);
    for (int j = 0; j < 4; j++) begin
      cand[j] = stream[SP-1-WB*j -: WB];
    end
    // silence word, and the fourth slot when only two words were full
    cand[4] = '0;
    if (!three) begin
      cand[3] = '0;
    end
    k = three ? PW'(3) : PW'(2);
    if (ir_last) begin
      k = k + PW'(2);
    end
    for (int j = 0; j < NW; j++) begin
      hit[j]   = (words_sent + 16'(j + 1)) >= limit;
      fin[j]   = ir_last && (PW'(j) == k - PW'(1));
      kmask[j] = PW'(j) < k;
    end
    m = k;
    for (int j = NW - 1; j >= 0; j--) begin
      if (kmask[j] && hit[j]) begin
        m = PW'(j + 1);
      end
    end
    if (stopped) begin
      m = '0;
    end
    rem          = total - (three ? (FW+3)'(3 * WB) : (FW+3)'(2 * WB));
    fill_next    = rem[FW-1:0];
    pending_next = three ? cand[3] : cand[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= lpwp_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      ir_red   <= red;
      ir_green <= green;
      ir_blue  <= blue;
      ir_last  <= last_led;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (in_take) begin
      ir_valid <= 1'b1;
    end else if (advance) begin
      ir_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= '0;
      fill       <= '0;
      words_sent <= '0;
      stopped    <= 1'b0;
    end else if (advance) begin
      if (ir_last) begin
        pending    <= '0;
        fill       <= '0;
        words_sent <= '0;
        stopped    <= 1'b0;
      end else if (!stopped) begin
        pending    <= pending_next;
        fill       <= fill_next;
        words_sent <= words_sent + 16'(m);
        stopped    <= |(hit & kmask);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int j = 0; j < NW; j++) begin
        entries[j].data      <= cand[j];
        entries[j].last_word <= fin[j] || hit[j];
        entries[j].limit_hit <= hit[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      left   <= '0;
    end else if (advance) begin
      rd_ptr <= '0;
      left   <= m;
    end else if (out_take) begin
      rd_ptr <= rd_ptr + PW'(1);
      left   <= left - PW'(1);
    end
  end

endmodule

`default_nettype wire

### test/lpwp_checker.sv
// checker for the led pulse word packer: predicts the slot words and compares each one
`timescale 1ns / 1ps

module lpwp_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic        last_led,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] word,
  input  logic        last_word,
  input  logic        limit_hit,
  output int          fail_count,
  output int          pending_words,
  output int          words_checked,
  output int          leds_packed
);

  localparam int FW = lpwp_pkg::FILL_W;
  localparam logic [FW-1:0] TOP_SLOT = FW'(lpwp_pkg::WORD_BITS - 1);

  logic [15:0]       word_limit;
  lpwp_pkg::word_t   partial_word;
  logic [FW-1:0]     slot_pos;
  logic [15:0]       frame_words;
  logic              halted;
  lpwp_pkg::entry_t  expected_words[$];
  int                errors = 0;
  int                checked = 0;
  int                leds_seen = 0;

  function automatic void clear_frame();
    partial_word = '0;
    slot_pos = TOP_SLOT;
    frame_words = '0;
    halted = 1'b0;
  endfunction

  function automatic void emit_word(lpwp_pkg::word_t w, logic closing);
    lpwp_pkg::entry_t e;
    if (halted) return;
    frame_words = frame_words + 16'd1;
    e.data = w;
    e.limit_hit = (frame_words >= word_limit);
    e.last_word = closing | e.limit_hit;
    if (e.limit_hit) halted = 1'b1;
    expected_words.push_back(e);
  endfunction

  function automatic void add_slot(logic s);
    if (halted) return;
    partial_word[slot_pos] = s;
    if (slot_pos == '0) begin
      emit_word(partial_word, 1'b0);
      partial_word = '0;
      slot_pos = TOP_SLOT;
    end else begin
      slot_pos = slot_pos - FW'(1);
    end
  endfunction

  // green, red, blue, msb first
  function automatic void pack_led(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic last);
    logic [23:0] bits;
    bits = {g, r, b};
    for (int i = 23; i >= 0; i--) begin
      add_slot(1'b1);
      add_slot(bits[i]);
      add_slot(1'b0);
    end
    if (last) begin
      emit_word(partial_word, 1'b0);
      emit_word('0, 1'b1);
      clear_frame();
    end
  endfunction

  function automatic void report_field(string what, logic [31:0] want, logic [31:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
  endfunction

  always @(posedge clk) begin
    lpwp_pkg::entry_t want;
    if (rst) begin
      word_limit = lpwp_pkg::LIMIT_RESET;
      clear_frame();
      expected_words.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report_field("word with none waiting", '0, word);
        end else begin
          want = expected_words.pop_front();
          checked++;
          if (word !== want.data) report_field("word", want.data, word);
          if (last_word !== want.last_word)
            report_field("last_word", 32'(want.last_word), 32'(last_word));
          if (limit_hit !== want.limit_hit)
            report_field("limit_hit", 32'(want.limit_hit), 32'(limit_hit));
        end
      end
      if (cfg_wr_en) word_limit = cfg_wr_data;
      if (in_valid && !in_stall) begin
        if (!halted) leds_seen++;
        pack_led(red, green, blue, last_led);
      end
    end
    fail_count <= errors;
    pending_words <= expected_words.size();
    words_checked <= checked;
    leds_packed <= leds_seen;
  end

endmodule

### test/tb.sv
// testbench top for the led pulse word packer: stimulus, idling and verdict
`timescale 1ns / 1ps

module tb;

  localparam int IDLE_LIMIT  = 2000;
  localparam int LONG_HOLD   = 120;
  localparam int RANDOM_LEDS = 350;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic [7:0]  red = '0;
  logic [7:0]  green = '0;
  logic [7:0]  blue = '0;
  logic        last_led = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [31:0] word;
  logic        last_word;
  logic        limit_hit;

  int fail_count;
  int pending_words;
  int words_checked;
  int leds_packed;
  int hold_reqs = 0;
  int burst_left = 0;
  int frames_sent = 0;
  int leds_offered = 0;
  int limits_set = 0;
  int idle_cycles = 0;

  always #1 clk = ~clk;

  led_pulse_word_packer u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .last_led    (last_led),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .word        (word),
    .last_word   (last_word),
    .limit_hit   (limit_hit)
  );

  lpwp_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .last_led      (last_led),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .word          (word),
    .last_word     (last_word),
    .limit_hit     (limit_hit),
    .fail_count    (fail_count),
    .pending_words (pending_words),
    .words_checked (words_checked),
    .leds_packed   (leds_packed)
  );

  function automatic logic [7:0] pick_colour();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_led(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                          input logic last);
    in_valid <= 1'b1;
    red <= r;
    green <= g;
    blue <= b;
    last_led <= last;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    leds_offered++;
  endtask

  task automatic offer_led(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                           input logic last);
    int gap;
    send_led(r, g, b, last);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        red <= 8'($urandom);
        green <= 8'($urandom);
        blue <= 8'($urandom);
        last_led <= 1'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++)
      offer_led(pick_colour(), pick_colour(), pick_colour(), i == len - 1);
    frames_sent++;
  endtask

  // wait for every expected word, then let any dropped items clear the block
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limits_set++;
  endtask

  // receiver stall pattern
  initial begin
    int seen_holds;
    int phase_left;
    int pct;
    int hold_left;
    seen_holds = 0;
    phase_left = 0;
    pct = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != seen_holds) begin
        seen_holds = hold_reqs;
        hold_left = LONG_HOLD;
      end
      if (phase_left == 0) begin
        phase_left = $urandom_range(10, 60);
        case ($urandom_range(0, 3))
          0: pct = 0;
          1: pct = 20;
          2: pct = 50;
          default: pct = 85;
        endcase
      end
      phase_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        cfg_wr_en)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d cycles with nothing accepted", idle_cycles);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int target;
    int phase_mark;
    int phase;
    logic [15:0] lim;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // four leds fill whole words, so the flushed word is empty
    offer_led(8'h00, 8'h00, 8'h00, 1'b0);
    offer_led(8'hff, 8'hff, 8'hff, 1'b0);
    offer_led(8'haa, 8'h55, 8'hf0, 1'b0);
    offer_led(8'h01, 8'h80, 8'h7f, 1'b1);
    offer_led(8'h12, 8'h34, 8'h56, 1'b1);
    // limit of one: rest of frame dropped, then a fresh frame
    write_limit(16'd1);
    offer_led(8'hff, 8'h00, 8'hff, 1'b0);
    offer_led(8'h00, 8'hff, 8'h00, 1'b1);
    offer_led(8'h5a, 8'ha5, 8'h3c, 1'b1);
    // limit of zero behaves as one
    write_limit(16'd0);
    offer_led(8'h0f, 8'hf0, 8'hc3, 1'b0);
    offer_led(8'h80, 8'h01, 8'h7e, 1'b1);
    // flush word reaches the limit
    write_limit(16'd3);
    offer_led(8'h96, 8'h69, 8'h81, 1'b1);
    // silence word reaches the limit
    write_limit(16'd4);
    offer_led(8'hfe, 8'h7f, 8'h01, 1'b1);
    write_limit(16'hffff);
    offer_led(8'hff, 8'h00, 8'h00, 1'b0);
    offer_led(8'h00, 8'hff, 8'h00, 1'b0);
    offer_led(8'h00, 8'h00, 8'hff, 1'b1);
    frames_sent += 8;
    drain();

    target = leds_offered + RANDOM_LEDS;
    phase = 0;
    while (leds_offered < target) begin
      case (phase % 5)
        0: lim = 16'($urandom_range(1, 12));
        1: lim = 16'hffff;
        2: lim = 16'($urandom_range(13, 80));
        3: lim = 16'($urandom);
        default: lim = '0;
      endcase
      write_limit(lim);
      if (phase % 4 == 1) begin
        // receiver holds off while items keep coming
        hold_reqs <= hold_reqs + 1;
        for (int i = 0; i < 16; i++)
          send_led(pick_colour(), pick_colour(), pick_colour(), i == 15);
        frames_sent++;
      end
      phase_mark = leds_offered;
      while (leds_offered < phase_mark + 60 && leds_offered < target)
        send_frame(($urandom_range(0, 5) == 0) ? $urandom_range(7, 30) : $urandom_range(1, 6));
      phase++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d leds (%0d packed before any limit) in %0d frames, %0d words checked",
             leds_offered, leds_packed, frames_sent, words_checked);
    $display("%0d word limit writes, including 0, 1, 3, 4, 65535 and random values",
             limits_set);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
